// ===== src/dual_motor_ramp_pwm_drive_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the dual motor ramp PWM drive
// Shared property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef DUAL_MOTOR_RAMP_PWM_DRIVE_TOP_DEFINES_SVH
`define DUAL_MOTOR_RAMP_PWM_DRIVE_TOP_DEFINES_SVH

// Property checked at every rising clock edge outside reset.
`define DMR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Property checked at every rising clock edge, reset included.
`define DMR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

// ===== src/dmr_pkg.sv =====
// ----------------------------------------------------------------------------
// Dual motor ramp PWM drive package
// Types, register indexes and fixed constants shared by the drive modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dmr_pkg;

   // Direction codes; the unused code is handled as neutral.
   localparam logic [1:0] DIR_NEUTRAL = 2'd0;
   localparam logic [1:0] DIR_FORWARD = 2'd1;
   localparam logic [1:0] DIR_REVERSE = 2'd2;

   // Configuration register indexes.
   localparam int unsigned CSR_ADDR_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH = 10;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_PWM_PERIOD = 2'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_ACCEL_STEP = 2'd1;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_DECEL_STEP = 2'd2;

   localparam int unsigned PERIOD_WIDTH  = 10;
   localparam int unsigned STEP_WIDTH    = 9;
   localparam int unsigned LIMIT_WIDTH   = 12;
   localparam int unsigned COMPARE_WIDTH = 10;
   localparam int unsigned RSP_TDATA_WIDTH = 24;

   localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = 10'd650;
   localparam logic [STEP_WIDTH-1:0]   ACCEL_RESET  = 9'd10;
   localparam logic [STEP_WIDTH-1:0]   DECEL_RESET  = 9'd20;

   // The floored limit is 100 * q with q clamped to 40, so the scale factor
   // (4000 - limit) / 4000 becomes gain / 40 with gain = 40 - q.
   localparam int unsigned GAIN_WIDTH = 6;
   localparam logic [GAIN_WIDTH-1:0] LIMIT_STEPS = 6'd40;

   // raw / 100 = (raw >> 2) / 25 = ((raw >> 2) * 1311) >> 15, exact for 12 bits.
   localparam int unsigned RECIP_HUNDRED_WIDTH = 11;
   localparam int unsigned RECIP_HUNDRED_SHIFT = 15;
   localparam logic [RECIP_HUNDRED_WIDTH-1:0] RECIP_HUNDRED = 11'd1311;

   // x / 40 = (x >> 3) / 5 = ((x >> 3) * 13108) >> 16, exact below 2^13.
   localparam int unsigned SCALED_WIDTH      = 16;
   localparam int unsigned DIV_IN_WIDTH      = 13;
   localparam int unsigned RECIP_FIVE_WIDTH  = 14;
   localparam int unsigned RECIP_FIVE_SHIFT  = 16;
   localparam logic [RECIP_FIVE_WIDTH-1:0] RECIP_FIVE = 14'd13108;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCALE,
      ST_PRODUCT,
      ST_DIVIDE
   } state_type;

   typedef struct packed {
      logic load_ramp;
      logic load_scale;
      logic load_product;
      logic load_result;
   } dp_cmd_type;

endpackage

`default_nettype wire

// ===== src/dmr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Dual motor ramp PWM drive controller
// Sequences one word through ramp, scale, product and divide steps and owns
// the result valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmr_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output dmr_pkg::dp_cmd_type   cmd
);

   dmr_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dmr_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = dmr_pkg::ST_SCALE;
         end
         dmr_pkg::ST_SCALE:   state_in = dmr_pkg::ST_PRODUCT;
         dmr_pkg::ST_PRODUCT: state_in = dmr_pkg::ST_DIVIDE;
         dmr_pkg::ST_DIVIDE: begin
            // The finished word waits here until the output register is free.
            if (out_free) state_in = dmr_pkg::ST_IDLE;
         end
         default: state_in = dmr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready        = 1'b0;
      cmd.load_ramp     = 1'b0;
      cmd.load_scale    = 1'b0;
      cmd.load_product  = 1'b0;
      cmd.load_result   = 1'b0;
      case (state_ff)
         dmr_pkg::ST_IDLE: begin
            req_tready    = 1'b1;
            cmd.load_ramp = req_tvalid;
         end
         dmr_pkg::ST_SCALE:   cmd.load_scale   = 1'b1;
         dmr_pkg::ST_PRODUCT: cmd.load_product = 1'b1;
         dmr_pkg::ST_DIVIDE:  cmd.load_result  = out_free;
         default: req_tready = 1'b0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dmr_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== src/dmr_datapath.sv =====
// ----------------------------------------------------------------------------
// Dual motor ramp PWM drive datapath
// Holds configuration and motor state, ramps both motors and scales their
// magnitudes into PWM compare values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmr_datapath #(
   parameter int MAGNITUDE_BITS = 9,
   localparam int REQ_TDATA_WIDTH = ((2 * MAGNITUDE_BITS + 16 + 7) / 8) * 8
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire dmr_pkg::dp_cmd_type                    cmd,
   input  wire logic [REQ_TDATA_WIDTH-1:0]             req_tdata,
   input  wire logic                                   csr_we,
   input  wire logic [dmr_pkg::CSR_ADDR_WIDTH-1:0]     csr_addr,
   input  wire logic [dmr_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata,
   output logic [dmr_pkg::RSP_TDATA_WIDTH-1:0]         rsp_tdata
);

   localparam int MB = MAGNITUDE_BITS;
   localparam int RW = ((MB > dmr_pkg::STEP_WIDTH) ? MB : dmr_pkg::STEP_WIDTH) + 1;
   localparam int SW = dmr_pkg::PERIOD_WIDTH + MB;
   localparam int QW = dmr_pkg::LIMIT_WIDTH - 2 + dmr_pkg::RECIP_HUNDRED_WIDTH;
   localparam int DW = dmr_pkg::DIV_IN_WIDTH + dmr_pkg::RECIP_FIVE_WIDTH;
   localparam int CW = dmr_pkg::COMPARE_WIDTH;

   // Field offsets within req_tdata.
   localparam int LD_LO  = 0;
   localparam int LM_LO  = 2;
   localparam int RD_LO  = MB + 2;
   localparam int RM_LO  = MB + 4;
   localparam int LIM_LO = 2 * MB + 4;

   function automatic logic [MB+1:0] next_motor(
      input logic [1:0]                     dir,
      input logic [MB-1:0]                  mag,
      input logic [1:0]                     want_dir,
      input logic [MB-1:0]                  want_mag,
      input logic [dmr_pkg::STEP_WIDTH-1:0] accel,
      input logic [dmr_pkg::STEP_WIDTH-1:0] decel
   );
      logic [1:0]    wd;
      logic [1:0]    nd;
      logic [MB-1:0] nm;
      logic [RW-1:0] m;
      logic [RW-1:0] tgt;
      logic [RW-1:0] down;
      logic [RW-1:0] up;
      wd   = (want_dir == dmr_pkg::DIR_FORWARD || want_dir == dmr_pkg::DIR_REVERSE) ?
             want_dir : dmr_pkg::DIR_NEUTRAL;
      m    = RW'(mag);
      tgt  = RW'(want_mag);
      down = (m > RW'(decel)) ? m - RW'(decel) : '0;
      up   = m + RW'(accel);
      nd   = dir;
      nm   = mag;
      if (wd == dmr_pkg::DIR_NEUTRAL || (wd != dir && dir != dmr_pkg::DIR_NEUTRAL)) begin
         // Stopping or reversing: run down to zero, then drop to neutral.
         nm = down[MB-1:0];
         if (down == '0) nd = dmr_pkg::DIR_NEUTRAL;
      end else begin
         nd = wd;
         if (tgt > m) begin
            nm = (up > tgt) ? want_mag : up[MB-1:0];
         end else if (tgt < m) begin
            nm = (down < tgt) ? want_mag : down[MB-1:0];
         end
      end
      return {nd, nm};
   endfunction

   logic [dmr_pkg::PERIOD_WIDTH-1:0] period_ff;
   logic [dmr_pkg::STEP_WIDTH-1:0]   accel_ff;
   logic [dmr_pkg::STEP_WIDTH-1:0]   decel_ff;

   logic [1:0]    dir_ff [2];
   logic [MB-1:0] mag_ff [2];
   logic [MB+1:0] motor_in [2];

   logic [QW-1:0]                   hundreds;
   logic [dmr_pkg::GAIN_WIDTH-1:0]  steps;
   logic [dmr_pkg::GAIN_WIDTH-1:0]  gain_in;
   logic [dmr_pkg::GAIN_WIDTH-1:0]  gain_ff;

   logic [SW-1:0]                        scale_prod [2];
   logic [CW-1:0]                        duty_ff    [2];
   logic [dmr_pkg::SCALED_WIDTH-1:0]     limit_prod [2];
   logic [dmr_pkg::DIV_IN_WIDTH-1:0]     scaled_ff  [2];
   logic [DW-1:0]                        div_prod   [2];
   logic [CW-1:0]                        compare    [2];
   logic [dmr_pkg::RSP_TDATA_WIDTH-1:0]  rsp_data_ff, rsp_data_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= dmr_pkg::PERIOD_RESET;
         accel_ff  <= dmr_pkg::ACCEL_RESET;
         decel_ff  <= dmr_pkg::DECEL_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            dmr_pkg::CSR_PWM_PERIOD: period_ff <= csr_wdata[dmr_pkg::PERIOD_WIDTH-1:0];
            dmr_pkg::CSR_ACCEL_STEP: accel_ff  <= csr_wdata[dmr_pkg::STEP_WIDTH-1:0];
            dmr_pkg::CSR_DECEL_STEP: decel_ff  <= csr_wdata[dmr_pkg::STEP_WIDTH-1:0];
            default: period_ff <= period_ff;
         endcase
      end
   end

   assign motor_in[0] = next_motor(dir_ff[0], mag_ff[0], req_tdata[LD_LO +: 2],
                                   req_tdata[LM_LO +: MB], accel_ff, decel_ff);
   assign motor_in[1] = next_motor(dir_ff[1], mag_ff[1], req_tdata[RD_LO +: 2],
                                   req_tdata[RM_LO +: MB], accel_ff, decel_ff);

   // The limit sample in hundreds, clamped to forty, sets the remaining gain.
   assign hundreds = QW'(req_tdata[LIM_LO + 2 +: dmr_pkg::LIMIT_WIDTH - 2]) *
                     QW'(dmr_pkg::RECIP_HUNDRED);
   assign steps    = hundreds[dmr_pkg::RECIP_HUNDRED_SHIFT +: dmr_pkg::GAIN_WIDTH];
   assign gain_in  = dmr_pkg::LIMIT_STEPS -
                     ((steps > dmr_pkg::LIMIT_STEPS) ? dmr_pkg::LIMIT_STEPS : steps);

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff[0] <= dmr_pkg::DIR_NEUTRAL;
         dir_ff[1] <= dmr_pkg::DIR_NEUTRAL;
         mag_ff[0] <= '0;
         mag_ff[1] <= '0;
      end else if (cmd.load_ramp) begin
         dir_ff[0] <= motor_in[0][MB+1:MB];
         dir_ff[1] <= motor_in[1][MB+1:MB];
         mag_ff[0] <= motor_in[0][MB-1:0];
         mag_ff[1] <= motor_in[1][MB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_ramp) gain_ff <= gain_in;
   end

   for (genvar i = 0; i < 2; i++) begin : g_motor
      assign scale_prod[i] = SW'(period_ff) * SW'(mag_ff[i]);
      assign limit_prod[i] = dmr_pkg::SCALED_WIDTH'(duty_ff[i]) *
                             dmr_pkg::SCALED_WIDTH'(gain_ff);
      assign div_prod[i]   = DW'(scaled_ff[i]) * DW'(dmr_pkg::RECIP_FIVE);
      assign compare[i]    = div_prod[i][dmr_pkg::RECIP_FIVE_SHIFT +: CW];

      always_ff @(posedge clock) begin
         if (cmd.load_scale) duty_ff[i] <= scale_prod[i][MB +: CW];
         if (cmd.load_product) begin
            scaled_ff[i] <= limit_prod[i][dmr_pkg::SCALED_WIDTH-1:3];
         end
      end
   end

   assign rsp_data_in = {2'b00,
                         compare[1], dir_ff[1] == dmr_pkg::DIR_FORWARD,
                         compare[0], dir_ff[0] == dmr_pkg::DIR_FORWARD};

   always_ff @(posedge clock) begin
      if (cmd.load_result) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tdata = rsp_data_ff;

endmodule

`default_nettype wire

// ===== src/dual_motor_ramp_pwm_drive_top.sv =====
// Dual motor ramp PWM drive.
// Each word on the req_ stream is one update tick: wanted direction and
// magnitude for the left and right motors and a raw speed-limit sample.
// The block ramps each motor's magnitude towards the wanted value by the
// configured acceleration and deceleration steps, runs a motor down to zero
// and through neutral before it changes direction, and returns one rsp_ word
// per tick with each motor's direction pin and PWM compare value.
// Each accepted word runs through the controller's four steps (ramp,
// period scale, limit product, divide), one multiplier stage each, and sets
// rsp_tvalid from the divide step; only then is a new word taken.
// A finished word sits in the output register while the next one is taken.
// If the receiver stalls, the following word waits in its divide step and
// req_tready stays low until the output register is free.
// Reset clears both motors to neutral at zero magnitude, restores the
// registers to period 650, acceleration 10 and deceleration 20, and empties
// the output. Registers are written on csr_we and should change only idle.
// ----------------------------------------------------------------------------
// Dual motor ramp PWM drive top level
// Stream ports, configuration port, controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dual_motor_ramp_pwm_drive_top #(
   parameter int MAGNITUDE_BITS = 9,
   localparam int REQ_TDATA_WIDTH = ((2 * MAGNITUDE_BITS + 16 + 7) / 8) * 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // left_want_direction, left_want_magnitude, right_want_direction,
   // right_want_magnitude, raw_speed_limit, zero padding
   input  wire logic [REQ_TDATA_WIDTH-1:0]           req_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // left_dir_pin, left_compare, right_dir_pin, right_compare, zero padding
   output logic [dmr_pkg::RSP_TDATA_WIDTH-1:0]       rsp_tdata,
   input  wire logic                                 csr_we,
   input  wire logic [dmr_pkg::CSR_ADDR_WIDTH-1:0]   csr_addr,
   input  wire logic [dmr_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   dmr_pkg::dp_cmd_type cmd;

   dmr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   dmr_datapath #(
      .MAGNITUDE_BITS (MAGNITUDE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule

`default_nettype wire

// ===== src/dmr_checker.sv =====
// ----------------------------------------------------------------------------
// Dual motor ramp PWM drive port checker
// Watches the stream ports of the top level for sequencing errors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "dual_motor_ramp_pwm_drive_top_defines.svh"

module dmr_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_tvalid,
   input wire logic                                req_tready,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [dmr_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata
);

   // A stalled result word must hold.
   `DMR_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "rsp word changed while stalled")

   // Reset leaves the output empty.
   `DMR_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "rsp_tvalid high after reset")

   // One tick is worked on at a time.
   `DMR_ASSERT(a_one_at_once, clock, reset, req_tvalid && req_tready |=> !req_tready, "req word taken while busy")

   // With the output free at acceptance, a tick's result must show on rsp_tvalid.
   `DMR_ASSERT(a_latency, clock, reset, req_tvalid && req_tready && !rsp_tvalid |-> ##4 rsp_tvalid, "result late")

endmodule

bind dual_motor_ramp_pwm_drive_top dmr_checker u_dmr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ===== sim/tb_dual_motor_ramp_pwm_drive_top.sv =====
// ----------------------------------------------------------------------------
// Dual motor ramp PWM drive testbench
// Drives update ticks into the req_ stream and checks every rsp_ word against
// a behavioural model of the ramp and compare arithmetic. The run has a short
// directed part at reset values and register extremes, then random phases with fresh
// register settings, random gaps on the sender and stalls on the receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_dual_motor_ramp_pwm_drive_top;

   localparam int MAG_W          = 9;
   localparam int REQ_W          = ((2 * MAG_W + 16 + 7) / 8) * 8;
   localparam int LIMIT_SPAN     = 4000;
   localparam int LIMIT_QUANT    = 100;
   localparam int COMPARE_MAX    = 1023;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int DRAIN_CYCLES   = 12;
   localparam int PHASE_TICKS    = 90;
   localparam int RANDOM_PHASES  = 8;
   localparam logic [dmr_pkg::CSR_ADDR_WIDTH-1:0] CSR_UNUSED = 2'd3;
   localparam logic [1:0] DIR_UNUSED = 2'd3;

   typedef struct packed {
      logic [REQ_W-35:0] pad;
      logic [11:0]       raw_limit;
      logic [MAG_W-1:0]  right_mag;
      logic [1:0]        right_dir;
      logic [MAG_W-1:0]  left_mag;
      logic [1:0]        left_dir;
   } tick_word_type;

   typedef struct {
      logic                              left_pin;
      logic [dmr_pkg::COMPARE_WIDTH-1:0] left_cmp;
      logic                              right_pin;
      logic [dmr_pkg::COMPARE_WIDTH-1:0] right_cmp;
   } drive_word_type;

   logic                                 clock      = 1'b0;
   logic                                 reset      = 1'b1;
   logic                                 req_tvalid = 1'b0;
   logic                                 req_tready;
   logic [REQ_W-1:0]                     req_tdata  = '0;
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   logic [dmr_pkg::RSP_TDATA_WIDTH-1:0]  rsp_tdata;
   logic                                 csr_we     = 1'b0;
   logic [dmr_pkg::CSR_ADDR_WIDTH-1:0]   csr_addr   = '0;
   logic [dmr_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata  = '0;

   // Model of the block's registers and motor state.
   logic [dmr_pkg::PERIOD_WIDTH-1:0] cfg_period = dmr_pkg::PERIOD_RESET;
   logic [dmr_pkg::STEP_WIDTH-1:0]   cfg_accel  = dmr_pkg::ACCEL_RESET;
   logic [dmr_pkg::STEP_WIDTH-1:0]   cfg_decel  = dmr_pkg::DECEL_RESET;
   logic [1:0]       act_dir [2] = '{dmr_pkg::DIR_NEUTRAL, dmr_pkg::DIR_NEUTRAL};
   logic [MAG_W-1:0] act_mag [2] = '{'0, '0};

   tick_word_type  tick_q[$];
   drive_word_type drive_word_q[$];
   logic        req_taken     = 1'b0;
   bit          no_idle       = 1'b0;
   int          send_gap      = 0;
   int          recv_stall    = 0;
   int unsigned ticks_queued  = 0;
   int unsigned ticks_taken   = 0;
   int unsigned results_seen  = 0;
   int unsigned csr_writes    = 0;
   int unsigned error_count   = 0;
   int unsigned cycle_count   = 0;
   logic [1:0]       targ_dir [2] = '{dmr_pkg::DIR_FORWARD, dmr_pkg::DIR_REVERSE};
   logic [MAG_W-1:0] targ_mag [2] = '{MAG_W'(511), MAG_W'(511)};

   dual_motor_ramp_pwm_drive_top #(.MAGNITUDE_BITS(MAG_W)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [MAG_W-1:0] ramp_down(logic [MAG_W-1:0] mag,
                                                  logic [MAG_W-1:0] target);
      logic [MAG_W-1:0] stepped;
      stepped = (mag > cfg_decel) ? mag - cfg_decel : '0;
      return (stepped < target) ? target : stepped;
   endfunction

   function automatic logic [MAG_W-1:0] ramp_up(logic [MAG_W-1:0] mag,
                                                logic [MAG_W-1:0] target);
      logic [MAG_W:0] stepped;
      stepped = mag + cfg_accel;
      return (stepped > target) ? target : stepped[MAG_W-1:0];
   endfunction

   function automatic void advance_motor(int m, logic [1:0] want_dir,
                                         logic [MAG_W-1:0] want_mag);
      logic [1:0]       wdir;
      logic [1:0]       dir;
      logic [MAG_W-1:0] mag;
      wdir = (want_dir > dmr_pkg::DIR_REVERSE) ? dmr_pkg::DIR_NEUTRAL : want_dir;
      dir  = act_dir[m];
      mag  = act_mag[m];
      // A reversal runs the motor down to zero and through neutral first.
      if (wdir == dmr_pkg::DIR_NEUTRAL ||
          (wdir != dir && dir != dmr_pkg::DIR_NEUTRAL)) begin
         mag = ramp_down(mag, '0);
         if (mag == '0)
            dir = dmr_pkg::DIR_NEUTRAL;
      end else begin
         dir = wdir;
         if (want_mag > mag)
            mag = ramp_up(mag, want_mag);
         else if (want_mag < mag)
            mag = ramp_down(mag, want_mag);
      end
      act_dir[m] = dir;
      act_mag[m] = mag;
   endfunction

   function automatic logic [dmr_pkg::COMPARE_WIDTH-1:0] duty_compare(
      logic [MAG_W-1:0] mag, int unsigned limit);
      longint unsigned scaled;
      scaled = 64'(cfg_period);
      scaled = (scaled * mag) >> MAG_W;
      scaled = scaled * (LIMIT_SPAN - limit) / LIMIT_SPAN;
      return (scaled > COMPARE_MAX) ? COMPARE_MAX[dmr_pkg::COMPARE_WIDTH-1:0]
                                    : scaled[dmr_pkg::COMPARE_WIDTH-1:0];
   endfunction

   function automatic drive_word_type ramp_and_scale(tick_word_type t);
      int unsigned    limit;
      drive_word_type res;
      limit = 32'(t.raw_limit);
      limit = (limit / LIMIT_QUANT) * LIMIT_QUANT;
      if (limit > LIMIT_SPAN)
         limit = LIMIT_SPAN;
      advance_motor(0, t.left_dir, t.left_mag);
      advance_motor(1, t.right_dir, t.right_mag);
      res.left_pin  = (act_dir[0] == dmr_pkg::DIR_FORWARD);
      res.left_cmp  = duty_compare(act_mag[0], limit);
      res.right_pin = (act_dir[1] == dmr_pkg::DIR_FORWARD);
      res.right_cmp = duty_compare(act_mag[1], limit);
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      r = int'($urandom_range(0, 99));
      if (no_idle || r < 60)
         return 0;
      else if (r < 90)
         return int'($urandom_range(1, 3));
      return int'($urandom_range(8, 40));
   endfunction

   task automatic report_mismatch(string what, int unsigned got, int unsigned exp);
      $display("%0t ns: ERROR %s: got %0d, expected %0d", $time, what, got, exp);
      error_count++;
   endtask

   // Sender: holds a word until it is taken, then waits out a random gap.
   always @(negedge clock) begin
      logic          nv;
      tick_word_type nd;
      nv = req_tvalid;
      nd = req_tdata;
      if (reset) begin
         nv = 1'b0;
      end else begin
         if (req_tvalid && req_taken) begin
            nv = 1'b0;
            send_gap = pick_gap();
         end
         if (!nv) begin
            if (send_gap > 0)
               send_gap--;
            else if (tick_q.size() > 0) begin
               nv = 1'b1;
               nd = tick_q.pop_front();
            end
         end
      end
      req_tvalid <= nv;
      req_tdata  <= nd;
   end

   always @(negedge clock) begin
      logic nr;
      if (reset)
         nr = 1'b0;
      else if (no_idle)
         nr = 1'b1;
      else if (recv_stall > 0) begin
         recv_stall--;
         nr = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
         recv_stall = pick_gap();
         nr = (recv_stall == 0);
      end else
         nr = 1'b1;
      rsp_tready <= nr;
   end

   always @(posedge clock) begin
      drive_word_type want;
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            drive_word_q.push_back(ramp_and_scale(req_tdata));
            ticks_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (drive_word_q.size() == 0) begin
               report_mismatch("result word with nothing expected", rsp_tdata, 0);
            end else begin
               want = drive_word_q.pop_front();
               if (rsp_tdata[0] !== want.left_pin)
                  report_mismatch("left_dir_pin", rsp_tdata[0], want.left_pin);
               if (rsp_tdata[10:1] !== want.left_cmp)
                  report_mismatch("left_compare", rsp_tdata[10:1], want.left_cmp);
               if (rsp_tdata[11] !== want.right_pin)
                  report_mismatch("right_dir_pin", rsp_tdata[11], want.right_pin);
               if (rsp_tdata[21:12] !== want.right_cmp)
                  report_mismatch("right_compare", rsp_tdata[21:12], want.right_cmp);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timed out after %0d cycles", cycle_count);
         $display("tb_dual_motor_ramp_pwm_drive_top: errors");
         $finish;
      end
   end

   task automatic push_tick(logic [1:0] ld, logic [MAG_W-1:0] lm, logic [1:0] rd,
                            logic [MAG_W-1:0] rm, logic [11:0] lim);
      tick_word_type w;
      w.pad       = '0;
      w.raw_limit = lim;
      w.right_mag = rm;
      w.right_dir = rd;
      w.left_mag  = lm;
      w.left_dir  = ld;
      tick_q.push_back(w);
      ticks_queued++;
   endtask

   task automatic csr_write(logic [dmr_pkg::CSR_ADDR_WIDTH-1:0] idx,
                            logic [dmr_pkg::CSR_DATA_WIDTH-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      case (idx)
         dmr_pkg::CSR_PWM_PERIOD: cfg_period = val;
         dmr_pkg::CSR_ACCEL_STEP: cfg_accel  = val[dmr_pkg::STEP_WIDTH-1:0];
         dmr_pkg::CSR_DECEL_STEP: cfg_decel  = val[dmr_pkg::STEP_WIDTH-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      csr_writes++;
   endtask

   // Every word in flight has come back, then a few spare cycles pass.
   task automatic wait_drained();
      do
         @(negedge clock);
      while (ticks_taken != ticks_queued || drive_word_q.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic [dmr_pkg::CSR_DATA_WIDTH-1:0] pick_step();
      case ($urandom_range(0, 7))
         0:       return 0;
         1:       return 1;
         2:       return 10'h3FF;
         3:       return 511;
         4, 5:    return dmr_pkg::CSR_DATA_WIDTH'($urandom_range(1, 40));
         default: return dmr_pkg::CSR_DATA_WIDTH'($urandom_range(0, 1023));
      endcase
   endfunction

   function automatic logic [dmr_pkg::CSR_DATA_WIDTH-1:0] pick_period();
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return 1;
         2:       return 1023;
         3:       return 650;
         default: return dmr_pkg::CSR_DATA_WIDTH'($urandom_range(0, 1023));
      endcase
   endfunction

   function automatic logic [11:0] pick_limit();
      int r;
      r = int'($urandom_range(0, 9));
      if (r == 0)
         return 12'($urandom_range(4000, 4095));
      else if (r == 1)
         return 12'($urandom_range(0, 99));
      return 12'($urandom_range(0, 4095));
   endfunction

   // Mostly steady targets so the ramps run their full course; a tenth is noise.
   task automatic fill_random(int n);
      int r;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            push_tick(2'($urandom_range(0, 3)), MAG_W'($urandom_range(0, 511)),
                      2'($urandom_range(0, 3)), MAG_W'($urandom_range(0, 511)),
                      12'($urandom_range(0, 4095)));
         end else begin
            for (int m = 0; m < 2; m++) begin
               if ($urandom_range(0, 11) == 0) begin
                  r = int'($urandom_range(0, 99));
                  targ_dir[m] = (r < 40) ? dmr_pkg::DIR_FORWARD :
                                (r < 80) ? dmr_pkg::DIR_REVERSE :
                                (r < 92) ? dmr_pkg::DIR_NEUTRAL : DIR_UNUSED;
                  r = int'($urandom_range(0, 99));
                  targ_mag[m] = (r < 15) ? MAG_W'(511) :
                                (r < 25) ? MAG_W'(0) : MAG_W'($urandom_range(0, 511));
               end
            end
            push_tick(targ_dir[0], targ_mag[0], targ_dir[1], targ_mag[1], pick_limit());
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Register values straight out of reset, then a reversal request.
      push_tick(dmr_pkg::DIR_FORWARD, 511, dmr_pkg::DIR_REVERSE, 511, 0);
      push_tick(dmr_pkg::DIR_FORWARD, 511, dmr_pkg::DIR_REVERSE, 511, 0);
      push_tick(dmr_pkg::DIR_FORWARD, 511, dmr_pkg::DIR_REVERSE, 511, 0);
      push_tick(dmr_pkg::DIR_REVERSE, 511, dmr_pkg::DIR_FORWARD, 511, 0);
      wait_drained();

      // Widest period and steps; the step writes carry a tenth bit to drop.
      csr_write(dmr_pkg::CSR_PWM_PERIOD, 1023);
      csr_write(dmr_pkg::CSR_ACCEL_STEP, 10'h3FF);
      csr_write(dmr_pkg::CSR_DECEL_STEP, 10'h3FF);
      push_tick(dmr_pkg::DIR_FORWARD, 511, dmr_pkg::DIR_REVERSE, 511, 0);
      push_tick(dmr_pkg::DIR_FORWARD, 511, dmr_pkg::DIR_REVERSE, 511, 4095);
      push_tick(dmr_pkg::DIR_FORWARD, 511, dmr_pkg::DIR_REVERSE, 511, 4000);
      push_tick(dmr_pkg::DIR_FORWARD, 511, dmr_pkg::DIR_REVERSE, 511, 3999);
      push_tick(dmr_pkg::DIR_FORWARD, 511, dmr_pkg::DIR_REVERSE, 511, 99);
      push_tick(DIR_UNUSED, 511, dmr_pkg::DIR_NEUTRAL, 0, 2048);
      push_tick(dmr_pkg::DIR_REVERSE, 1, dmr_pkg::DIR_FORWARD, 0, 150);
      push_tick(dmr_pkg::DIR_FORWARD, 511, dmr_pkg::DIR_REVERSE, 300, 1234);
      push_tick(dmr_pkg::DIR_FORWARD, 511, dmr_pkg::DIR_REVERSE, 300, 1234);
      push_tick(dmr_pkg::DIR_FORWARD, 200, dmr_pkg::DIR_REVERSE, 511, 0);
      wait_drained();

      // Zero period and zero steps freeze the motors; the spare index is ignored.
      csr_write(dmr_pkg::CSR_PWM_PERIOD, 0);
      csr_write(dmr_pkg::CSR_ACCEL_STEP, 0);
      csr_write(dmr_pkg::CSR_DECEL_STEP, 0);
      csr_write(CSR_UNUSED, 10'h3FF);
      push_tick(dmr_pkg::DIR_FORWARD, 0, dmr_pkg::DIR_REVERSE, 0, 0);
      push_tick(dmr_pkg::DIR_NEUTRAL, 0, dmr_pkg::DIR_FORWARD, 0, 0);
      push_tick(dmr_pkg::DIR_FORWARD, 511, dmr_pkg::DIR_REVERSE, 511, 0);
      wait_drained();

      csr_write(dmr_pkg::CSR_PWM_PERIOD, 1);
      csr_write(dmr_pkg::CSR_ACCEL_STEP, 1);
      csr_write(dmr_pkg::CSR_DECEL_STEP, 1);
      push_tick(dmr_pkg::DIR_FORWARD, 511, dmr_pkg::DIR_REVERSE, 511, 0);
      push_tick(dmr_pkg::DIR_FORWARD, 511, dmr_pkg::DIR_REVERSE, 511, 0);
      push_tick(dmr_pkg::DIR_NEUTRAL, 511, DIR_UNUSED, 511, 4095);
      push_tick(dmr_pkg::DIR_REVERSE, 511, dmr_pkg::DIR_FORWARD, 511, 4095);
      wait_drained();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         no_idle = (p % 3 == 1);
         csr_write(dmr_pkg::CSR_PWM_PERIOD, pick_period());
         csr_write(dmr_pkg::CSR_ACCEL_STEP, pick_step());
         csr_write(dmr_pkg::CSR_DECEL_STEP, pick_step());
         csr_write(CSR_UNUSED, dmr_pkg::CSR_DATA_WIDTH'($urandom_range(0, 1023)));
         fill_random(PHASE_TICKS);
         wait_drained();
      end

      $display("%0d ticks sent, %0d result words checked", ticks_queued, results_seen);
      $display("%0d register writes over %0d random phases, %0d cycles",
               csr_writes, RANDOM_PHASES, cycle_count);
      if (error_count == 0)
         $display("tb_dual_motor_ramp_pwm_drive_top: clean");
      else
         $display("tb_dual_motor_ramp_pwm_drive_top: errors");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/dmr_pkg.sv
src/dmr_ctrl.sv
src/dmr_datapath.sv
src/dual_motor_ramp_pwm_drive_top.sv
src/dmr_checker.sv
sim/tb_dual_motor_ramp_pwm_drive_top.sv
